FILE: design/rlse_pkg.sv
package rlse_pkg;

    localparam int COLOUR_W  = 8;
    localparam int PATTERN_W = 4;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Reset values of the configuration registers.
    localparam logic [COLOUR_W-1:0]  BRIGHTNESS_RST   = 8'd255;
    localparam logic [PATTERN_W-1:0] PATTERN_ZERO_RST = 4'd8;
    localparam logic [PATTERN_W-1:0] PATTERN_ONE_RST  = 4'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS   = 2'd0,
        CFG_PATTERN_ZERO = 2'd1,
        CFG_PATTERN_ONE  = 2'd2
    } t_cfg_idx;

    // Word position within a pixel; each word carries one colour byte.
    typedef logic [1:0] t_word_cnt;
    localparam t_word_cnt WORD_GREEN = 2'd0;
    localparam t_word_cnt WORD_RED   = 2'd1;
    localparam t_word_cnt WORD_BLUE  = 2'd2;
    localparam t_word_cnt LAST_WORD  = WORD_BLUE;

    typedef struct packed {
        logic [COLOUR_W-1:0]  brightness;
        logic [PATTERN_W-1:0] pattern_zero;
        logic [PATTERN_W-1:0] pattern_one;
    } t_cfg;

    typedef struct packed {
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] blue;
        logic                frame_end;
    } t_pixel;

    function automatic logic [COLOUR_W-1:0] scale_colour(
        input logic [COLOUR_W-1:0] colour,
        input logic [COLOUR_W-1:0] brightness
    );
        logic [2*COLOUR_W-1:0] prod;
        prod = (2*COLOUR_W)'(colour) * (2*COLOUR_W)'(brightness);
        return prod[2*COLOUR_W-1:COLOUR_W];
    endfunction

    // Two data bits become one line byte, the earlier bit in the high nibble.
    function automatic logic [7:0] encode_pair(
        input logic [1:0] bits,
        input t_cfg       cfg
    );
        logic [PATTERN_W-1:0] hi;
        logic [PATTERN_W-1:0] lo;
        hi = bits[1] ? cfg.pattern_one : cfg.pattern_zero;
        lo = bits[0] ? cfg.pattern_one : cfg.pattern_zero;
        return {hi, lo};
    endfunction

    // One colour byte fills one word, byte pairs swapped for 16-bit framing.
    function automatic logic [WORD_W-1:0] encode_word(
        input logic [COLOUR_W-1:0] colour,
        input t_cfg                cfg
    );
        return {encode_pair(colour[3:2], cfg), encode_pair(colour[1:0], cfg),
                encode_pair(colour[7:6], cfg), encode_pair(colour[5:4], cfg)};
    endfunction

endpackage

FILE: design/rgb_led_serial_bit_encoder.sv
// Encodes one pixel (red, green, blue, frame_end) into three 32-bit line
// words for a 16-bit-framed serial link driving a chain of RGB LEDs.
// Input channel: i_in_valid / o_in_stall; a pixel is taken on a clock edge
// with valid high and stall low. Output channel: o_out_valid / i_out_stall
// carries drive_word, last_of_pixel and last_of_frame, one word per unstalled edge.
// Each colour is scaled by brightness, and each data bit becomes a four-bit
// line pattern, green first, most significant bit first.
// The input register, the encoder buffer and the output word register lie between
// a taken pixel and its first word. The single output word register issues
// the three words of a pixel one per cycle while the receiver does not stall;
// the next pixel enters the encoder buffer as the third word is issued.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready and
// should only be written while no pixel is in flight.
// Reset clears all pipeline stages and loads brightness 255, zero pattern 8
// and one pattern 14. A stalled receiver holds the current word; the stall
// backs up through the stages to o_in_stall without losing any word.
module rgb_led_serial_bit_encoder
    import rlse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COLOUR_W-1:0]   i_red,
    input  logic [COLOUR_W-1:0]   i_green,
    input  logic [COLOUR_W-1:0]   i_blue,
    input  logic                  i_frame_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_W-1:0]     o_drive_word,
    output logic                  o_last_of_pixel,
    output logic                  o_last_of_frame
);

    t_cfg   cfg;
    t_pixel scaled_pix;
    logic   scaled_vld;
    logic   enc_stall;
    logic   in_busy;

    rlse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rlse_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_frame_end (i_frame_end),
        .o_valid     (scaled_vld),
        .i_stall     (enc_stall),
        .o_pix       (scaled_pix),
        .o_busy      (in_busy)
    );

    rlse_enc u_enc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (scaled_vld),
        .o_stall         (enc_stall),
        .i_pix           (scaled_pix),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_drive_word    (o_drive_word),
        .o_last_of_pixel (o_last_of_pixel),
        .o_last_of_frame (o_last_of_frame)
    );

    // The frame mark only ever sits on the closing word of a pixel.
    a_frame_on_pixel_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_frame |-> o_last_of_pixel)
        else $error("last_of_frame without last_of_pixel");

    // Once a pixel's first or second word is taken, the next word follows at once.
    a_words_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_pixel |=> o_out_valid)
        else $error("gap inside the words of one pixel");

    // The input side only stalls while its register holds a pixel.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> in_busy)
        else $error("input stalled with an empty input register");

endmodule

FILE: design/rlse_cfg.sv
module rlse_cfg
    import rlse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness   <= BRIGHTNESS_RST;
            r_cfg.pattern_zero <= PATTERN_ZERO_RST;
            r_cfg.pattern_one  <= PATTERN_ONE_RST;
        end else if (i_cfg_valid) begin
            // An index beyond the register list is dropped.
            case (t_cfg_idx'(i_cfg_index))
                CFG_BRIGHTNESS:   r_cfg.brightness   <= i_cfg_data;
                CFG_PATTERN_ZERO: r_cfg.pattern_zero <= i_cfg_data[PATTERN_W-1:0];
                CFG_PATTERN_ONE:  r_cfg.pattern_one  <= i_cfg_data[PATTERN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: design/rlse_scale.sv
module rlse_scale
    import rlse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [COLOUR_W-1:0] i_red,
    input  logic [COLOUR_W-1:0] i_green,
    input  logic [COLOUR_W-1:0] i_blue,
    input  logic                i_frame_end,
    output logic                o_valid,
    input  logic                i_stall,
    output t_pixel              o_pix,
    output logic                o_busy
);

    logic   r_vld;
    t_pixel r_pix;

    assign o_stall = r_vld && i_stall;
    assign o_valid = r_vld;
    assign o_busy  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_pix.green     <= i_green;
            r_pix.red       <= i_red;
            r_pix.blue      <= i_blue;
            r_pix.frame_end <= i_frame_end;
        end
    end

    always_comb begin
        o_pix.green     = scale_colour(r_pix.green, i_cfg.brightness);
        o_pix.red       = scale_colour(r_pix.red, i_cfg.brightness);
        o_pix.blue      = scale_colour(r_pix.blue, i_cfg.brightness);
        o_pix.frame_end = r_pix.frame_end;
    end

endmodule

FILE: design/rlse_enc.sv
module rlse_enc
    import rlse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_pixel            i_pix,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_drive_word,
    output logic              o_last_of_pixel,
    output logic              o_last_of_frame
);

    logic              r_b_vld;
    t_pixel            r_b_pix;
    t_word_cnt         r_b_cnt;
    logic              r_o_vld;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_lop;
    logic              r_o_lof;

    logic                take;
    logic                emit;
    logic                b_done;
    logic [COLOUR_W-1:0] sel_byte;
    logic [WORD_W-1:0]   n_o_word;
    logic                n_o_lop;

    // The output register takes a word when it is empty or being drained.
    assign take    = !r_o_vld || !i_stall;
    assign emit    = r_b_vld && take;
    assign b_done  = emit && (r_b_cnt == LAST_WORD);
    assign o_stall = r_b_vld && !b_done;

    always_comb begin
        case (r_b_cnt)
            WORD_GREEN: sel_byte = r_b_pix.green;
            WORD_RED:   sel_byte = r_b_pix.red;
            default:    sel_byte = r_b_pix.blue;
        endcase
        n_o_word = encode_word(sel_byte, i_cfg);
        n_o_lop  = (r_b_cnt == LAST_WORD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_b_cnt <= WORD_GREEN;
        end else if (!o_stall) begin
            r_b_vld <= i_valid;
            r_b_cnt <= WORD_GREEN;
        end else if (emit) begin
            r_b_cnt <= r_b_cnt + t_word_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_b_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (take) begin
            r_o_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_word <= n_o_word;
            r_o_lop  <= n_o_lop;
            r_o_lof  <= n_o_lop && r_b_pix.frame_end;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_drive_word    = r_o_word;
    assign o_last_of_pixel = r_o_lop;
    assign o_last_of_frame = r_o_lof;

endmodule

FILE: sim/led_word_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, pixel and drive word channels of the encoder.
// It keeps its own copy of the registers, predicts the three drive words of
// every accepted pixel and compares each accepted word with the oldest one due.
module led_word_checker
    import rlse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [COLOUR_W-1:0]   i_red,
    input  logic [COLOUR_W-1:0]   i_green,
    input  logic [COLOUR_W-1:0]   i_blue,
    input  logic                  i_frame_end,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [WORD_W-1:0]     i_drive_word,
    input  logic                  i_last_of_pixel,
    input  logic                  i_last_of_frame,
    output int                    o_mismatches,
    output int                    o_words_due
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              pixel_end;
        logic              strip_end;
    } t_drive_entry;

    t_drive_entry         words_due[$];
    logic [COLOUR_W-1:0]  level;
    logic [PATTERN_W-1:0] zero_shape;
    logic [PATTERN_W-1:0] one_shape;
    int                   mismatches = 0;

    function automatic logic [COLOUR_W-1:0] dimmed(
        input logic [COLOUR_W-1:0] colour,
        input logic [COLOUR_W-1:0] scale
    );
        logic [2*COLOUR_W-1:0] product;
        product = {{COLOUR_W{1'b0}}, colour} * {{COLOUR_W{1'b0}}, scale};
        return product[2*COLOUR_W-1:COLOUR_W];
    endfunction

    function automatic logic [PATTERN_W-1:0] line_shape(input logic data_bit);
        return data_bit ? one_shape : zero_shape;
    endfunction

    task automatic predict_pixel_words(
        input logic [COLOUR_W-1:0] red,
        input logic [COLOUR_W-1:0] green,
        input logic [COLOUR_W-1:0] blue,
        input logic                frame_end
    );
        logic [3*COLOUR_W-1:0] stream;
        logic [7:0]            line_byte [12];
        t_drive_entry          entry;
        stream = {dimmed(green, level), dimmed(red, level), dimmed(blue, level)};
        // Two data bits per line byte, the earlier bit in the high nibble.
        for (int k = 0; k < 12; k++) begin
            line_byte[k] = {line_shape(stream[23 - 2*k]), line_shape(stream[22 - 2*k])};
        end
        // Byte pairs are swapped for the 16-bit framing of the serial link.
        for (int w = 0; w < 3; w++) begin
            entry.word      = {line_byte[4*w + 2], line_byte[4*w + 3],
                               line_byte[4*w], line_byte[4*w + 1]};
            entry.pixel_end = (w == 2);
            entry.strip_end = (w == 2) && frame_end;
            words_due.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin
        t_drive_entry due;
        if (!i_rst_n) begin
            words_due.delete();
            level      = BRIGHTNESS_RST;
            zero_shape = PATTERN_ZERO_RST;
            one_shape  = PATTERN_ONE_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BRIGHTNESS:   level      = i_cfg_data;
                    CFG_PATTERN_ZERO: zero_shape = i_cfg_data[PATTERN_W-1:0];
                    CFG_PATTERN_ONE:  one_shape  = i_cfg_data[PATTERN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_pixel_words(i_red, i_green, i_blue, i_frame_end);
            end
            if (i_out_valid && !i_out_stall) begin
                if (words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: drive word %08h with none due", $realtime,
                                 i_drive_word);
                    end
                end else begin
                    due = words_due.pop_front();
                    if (i_drive_word !== due.word || i_last_of_pixel !== due.pixel_end ||
                        i_last_of_frame !== due.strip_end) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: word exp %08h/%0b/%0b got %08h/%0b/%0b",
                                     $realtime, due.word, due.pixel_end, due.strip_end,
                                     i_drive_word, i_last_of_pixel, i_last_of_frame);
                        end
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_words_due  <= words_due.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import rlse_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASES         = 6;
    localparam int PIXELS_A_PHASE = 60;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [COLOUR_W-1:0]   i_red;
    logic [COLOUR_W-1:0]   i_green;
    logic [COLOUR_W-1:0]   i_blue;
    logic                  i_frame_end;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [WORD_W-1:0]     o_drive_word;
    logic                  o_last_of_pixel;
    logic                  o_last_of_frame;

    int   mismatches;
    int   words_due;
    logic quiet;
    int   hold_requests;
    int   holds_served;

    rgb_led_serial_bit_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive_word    (o_drive_word),
        .o_last_of_pixel (o_last_of_pixel),
        .o_last_of_frame (o_last_of_frame)
    );

    led_word_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_frame_end     (i_frame_end),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_drive_word    (o_drive_word),
        .i_last_of_pixel (o_last_of_pixel),
        .i_last_of_frame (o_last_of_frame),
        .o_mismatches    (mismatches),
        .o_words_due     (words_due)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("rgb_led_serial_bit_encoder regression: fail");
        $finish;
    end

    // Receiver: random stalls, and on request one long hold-off so that the
    // encoder backs up into its input.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 11);
            end
        end
    end

    task automatic send_pixel(
        input logic [COLOUR_W-1:0] red,
        input logic [COLOUR_W-1:0] green,
        input logic [COLOUR_W-1:0] blue,
        input logic                frame_end
    );
        i_in_valid  <= 1'b1;
        i_red       <= red;
        i_green     <= green;
        i_blue      <= blue;
        i_frame_end <= frame_end;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stops the pixel stream and waits until every predicted word has left.
    task automatic drain;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
    endtask

    task automatic put_reg(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_strip(
        input logic [CFG_DATA_W-1:0] level,
        input logic [CFG_DATA_W-1:0] zero_shape,
        input logic [CFG_DATA_W-1:0] one_shape
    );
        drain();
        put_reg(CFG_BRIGHTNESS, level);
        put_reg(CFG_PATTERN_ZERO, zero_shape);
        put_reg(CFG_PATTERN_ONE, one_shape);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [COLOUR_W-1:0] any_colour;
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return COLOUR_W'($urandom_range(255));
        endcase
    endfunction

    initial begin
        quiet         = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BRIGHTNESS;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_frame_end <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first, then the extremes of scale and line shapes.
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hAA, 8'h55, 8'hC3, 1'b0);
        send_pixel(8'h01, 8'h80, 8'h7E, 1'b1);
        // Upper bits of the pattern writes must be dropped.
        set_strip(8'h00, 8'hF3, 8'h5C);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        set_strip(8'h80, 8'h00, 8'h0F);
        send_pixel(8'hFF, 8'h00, 8'h80, 1'b0);
        send_pixel(8'h81, 8'hFF, 8'h01, 1'b1);
        set_strip(8'h01, 8'h0F, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hC8, 8'h64, 8'h32, 1'b1);
        // A write to the unused index must leave every register alone.
        drain();
        put_reg(CFG_UNUSED_IDX, 8'h00);
        i_cfg_valid <= 1'b0;
        send_pixel(8'h5A, 8'hA5, 8'hFF, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       set_strip(CFG_DATA_W'(BRIGHTNESS_RST),
                                   CFG_DATA_W'(PATTERN_ZERO_RST),
                                   CFG_DATA_W'(PATTERN_ONE_RST));
                2:       set_strip(8'hFE, 8'h0F, 8'h00);
                4:       set_strip(8'h01, CFG_DATA_W'($urandom_range(255)),
                                   CFG_DATA_W'($urandom_range(255)));
                default: set_strip(CFG_DATA_W'($urandom_range(255)),
                                   CFG_DATA_W'($urandom_range(255)),
                                   CFG_DATA_W'($urandom_range(255)));
            endcase
            quiet = (phase == 4);
            for (int n = 0; n < PIXELS_A_PHASE; n++) begin
                if (phase == 2 && n == 10) begin
                    hold_requests++;
                end
                if (phase == 3 && n == 20) begin
                    drain();
                end
                send_pixel(any_colour(), any_colour(), any_colour(),
                           $urandom_range(7) == 0);
            end
            quiet = 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && words_due == 0) begin
            $display("rgb_led_serial_bit_encoder regression: pass");
        end else begin
            $display("rgb_led_serial_bit_encoder regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/rlse_pkg.sv
design/rlse_cfg.sv
design/rlse_scale.sv
design/rlse_enc.sv
design/rgb_led_serial_bit_encoder.sv
sim/led_word_checker.sv
sim/tb.sv
